// ----- sv/trc_pkg.sv -----
// trc_pkg: shared types and constants for the thermostat relay controller
// used by the channel interfaces, the condition decoder and the top level
// no dependencies

package trc_pkg;

    // field and register widths
    localparam int TEMP_WIDTH      = 16;
    localparam int DELAY_WIDTH     = 24;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CODE_WIDTH      = 2;

    typedef logic signed [TEMP_WIDTH-1:0] temp_t;
    typedef logic [DELAY_WIDTH-1:0]       delay_t;
    typedef logic [CODE_WIDTH-1:0]        code_t;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_ON_THRESHOLD     = 3'd0,
        CFG_OFF_THRESHOLD    = 3'd1,
        CFG_CONTROL_MODE     = 3'd2,
        CFG_ON_DELAY_TICKS   = 3'd3,
        CFG_OFF_DELAY_TICKS  = 3'd4,
        CFG_ON_DELAY_ENABLE  = 3'd5,
        CFG_OFF_DELAY_ENABLE = 3'd6
    } cfg_index_t;

    // control modes
    typedef enum logic [1:0] {
        MODE_HEAT    = 2'd0,
        MODE_COOL    = 2'd1,
        MODE_INSIDE  = 2'd2,
        MODE_OUTSIDE = 2'd3
    } mode_t;

    // decided state, one-hot
    typedef enum logic [2:0] {
        ST_OFF       = 3'b001,
        ST_ON        = 3'b010,
        ST_UNDECIDED = 3'b100
    } state_t;

    // reported state codes
    localparam code_t ACTIVE_OFF       = 2'd0;
    localparam code_t ACTIVE_ON        = 2'd1;
    localparam code_t ACTIVE_UNDECIDED = 2'd2;

    // switch conditions from the decoder
    typedef struct packed {
        logic want_on;
        logic want_off;
    } want_t;

endpackage

// ----- sv/trc_in_if.sv -----
// trc_in_if: tick channel into the controller (valid/ready plus payload)
// depends on trc_pkg

interface trc_in_if;
    logic           valid;
    logic           ready;
    trc_pkg::temp_t temperature;
    logic           evaluate;
    logic           force_off;

    modport source (output valid, output temperature, output evaluate, output force_off,
                    input ready);
    modport sink   (input valid, input temperature, input evaluate, input force_off,
                    output ready);
endinterface

// ----- sv/trc_out_if.sv -----
// trc_out_if: result channel out of the controller (valid/ready plus payload)
// depends on trc_pkg

interface trc_out_if;
    logic           valid;
    logic           ready;
    logic           relay_on;
    trc_pkg::code_t active_code;

    modport source (output valid, output relay_on, output active_code, input ready);
    modport sink   (input valid, input relay_on, input active_code, output ready);
endinterface

// ----- sv/trc_decide.sv -----
// trc_decide: switch-on and switch-off conditions from temperature and thresholds
// depends on trc_pkg

module trc_decide (
    input  trc_pkg::temp_t temperature,
    input  trc_pkg::temp_t on_threshold,
    input  trc_pkg::temp_t off_threshold,
    input  trc_pkg::mode_t control_mode,
    output trc_pkg::want_t want
);

    logic outside;

    // above both thresholds or below both
    assign outside = ((temperature > on_threshold) && (temperature > off_threshold)) ||
                     ((temperature < on_threshold) && (temperature < off_threshold));

    // per-mode conditions
    always_comb
    begin
        unique case (control_mode)
            trc_pkg::MODE_HEAT:
            begin
                want.want_on  = (temperature <= on_threshold);
                want.want_off = (temperature >= off_threshold);
            end
            trc_pkg::MODE_COOL:
            begin
                want.want_on  = (temperature >= on_threshold);
                want.want_off = (temperature <= off_threshold);
            end
            trc_pkg::MODE_INSIDE:
            begin
                want.want_on  = !outside;
                want.want_off = outside;
            end
            trc_pkg::MODE_OUTSIDE:
            begin
                want.want_on  = outside;
                want.want_off = !outside;
            end
            default:
            begin
                want.want_on  = 1'b0;
                want.want_off = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/thermostat_relay_controller_unit.sv -----
// thermostat_relay_controller_unit: hysteresis thermostat with delayed relay drive
// depends on trc_pkg, trc_in_if, trc_out_if and trc_decide
//
// usage
// - in_ch carries one tick per transaction: temperature, evaluate, force_off
// - out_ch returns one transaction per tick: relay_on and active_code after it
// - cfg_write_en / cfg_index / cfg_data write the seven settings; write only
//   while no tick is in flight
// - the result is registered: a tick accepted at a clock edge shows its result
//   from the next cycle on
// - throughput is one tick per cycle; the result registers double as the
//   controller state, so a tick is taken whenever the result slot is empty
//   or being drained in the same cycle
// - when the receiver stalls, the pending result holds and in_ch.ready drops
//   until it is taken
// - reset clears all settings to zero, the decided state to undecided, both
//   delay counters to zero and opens the relay; no result is pending

module thermostat_relay_controller_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    trc_in_if.sink                               in_ch,
    trc_out_if.source                            out_ch,
    input  logic                                 cfg_write_en,
    input  logic [trc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [trc_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    // configuration registers
    trc_pkg::temp_t  on_threshold_reg;
    trc_pkg::temp_t  off_threshold_reg;
    trc_pkg::mode_t  control_mode_reg;
    trc_pkg::delay_t on_delay_ticks_reg;
    trc_pkg::delay_t off_delay_ticks_reg;
    logic            on_delay_enable_reg;
    logic            off_delay_enable_reg;

    // controller state
    trc_pkg::state_t state_reg,     state_next;
    trc_pkg::delay_t on_count_reg,  on_count_next;
    trc_pkg::delay_t off_count_reg, off_count_next;
    logic            relay_reg,     relay_next;
    logic            out_valid_reg;

    logic            accept;
    trc_pkg::want_t  want;
    trc_pkg::state_t state_mid;
    trc_pkg::delay_t on_count_adv;
    trc_pkg::delay_t off_count_adv;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_threshold_reg     <= '0;
            off_threshold_reg    <= '0;
            control_mode_reg     <= trc_pkg::MODE_HEAT;
            on_delay_ticks_reg   <= '0;
            off_delay_ticks_reg  <= '0;
            on_delay_enable_reg  <= 1'b0;
            off_delay_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (trc_pkg::cfg_index_t'(cfg_index))
                trc_pkg::CFG_ON_THRESHOLD:
                    on_threshold_reg <= trc_pkg::temp_t'(cfg_data[trc_pkg::TEMP_WIDTH-1:0]);
                trc_pkg::CFG_OFF_THRESHOLD:
                    off_threshold_reg <= trc_pkg::temp_t'(cfg_data[trc_pkg::TEMP_WIDTH-1:0]);
                trc_pkg::CFG_CONTROL_MODE:
                    control_mode_reg <= trc_pkg::mode_t'(cfg_data[1:0]);
                trc_pkg::CFG_ON_DELAY_TICKS:
                    on_delay_ticks_reg <= trc_pkg::DELAY_WIDTH'(cfg_data);
                trc_pkg::CFG_OFF_DELAY_TICKS:
                    off_delay_ticks_reg <= trc_pkg::DELAY_WIDTH'(cfg_data);
                trc_pkg::CFG_ON_DELAY_ENABLE:
                    on_delay_enable_reg <= cfg_data[0];
                trc_pkg::CFG_OFF_DELAY_ENABLE:
                    off_delay_enable_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    // handshake: take a tick when the result slot is free or draining
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    trc_decide u_decide (
        .temperature   (in_ch.temperature),
        .on_threshold  (on_threshold_reg),
        .off_threshold (off_threshold_reg),
        .control_mode  (control_mode_reg),
        .want          (want)
    );

    // saturating delay counters
    assign on_count_adv  = (on_count_reg < on_delay_ticks_reg) ?
                           on_count_reg + 1'b1 : on_count_reg;
    assign off_count_adv = (off_count_reg < off_delay_ticks_reg) ?
                           off_count_reg + 1'b1 : off_count_reg;

    // per-tick decision and relay update
    always_comb
    begin
        state_mid      = state_reg;
        state_next     = state_reg;
        on_count_next  = on_count_adv;
        off_count_next = off_count_adv;
        relay_next     = relay_reg;
        if (in_ch.force_off)
        begin
            relay_next = 1'b0;
        end
        else if (in_ch.evaluate)
        begin
            if (want.want_on && (state_reg != trc_pkg::ST_ON))
            begin
                state_mid     = trc_pkg::ST_ON;
                on_count_next = on_delay_enable_reg ? '0 : on_delay_ticks_reg;
            end
            state_next = state_mid;
            if (want.want_off && (state_mid != trc_pkg::ST_OFF))
            begin
                state_next     = trc_pkg::ST_OFF;
                off_count_next = off_delay_enable_reg ? '0 : off_delay_ticks_reg;
            end
            if ((on_count_next >= on_delay_ticks_reg) && (state_next == trc_pkg::ST_ON))
                relay_next = 1'b1;
            if ((off_count_next >= off_delay_ticks_reg) && (state_next == trc_pkg::ST_OFF))
                relay_next = 1'b0;
        end
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trc_pkg::ST_UNDECIDED;
            on_count_reg  <= '0;
            off_count_reg <= '0;
            relay_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                on_count_reg  <= on_count_next;
                off_count_reg <= off_count_next;
                relay_reg     <= relay_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_comb
    begin
        unique case (state_reg)
            trc_pkg::ST_OFF:       out_ch.active_code = trc_pkg::ACTIVE_OFF;
            trc_pkg::ST_ON:        out_ch.active_code = trc_pkg::ACTIVE_ON;
            trc_pkg::ST_UNDECIDED: out_ch.active_code = trc_pkg::ACTIVE_UNDECIDED;
            default:               out_ch.active_code = trc_pkg::ACTIVE_UNDECIDED;
        endcase
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.relay_on = relay_reg;

    // every accepted tick leaves a result pending
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted tick left no pending result");

    // relay only closes while the decided state is on
    a_relay_close_on: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(relay_reg) |-> (state_reg == trc_pkg::ST_ON))
        else $error("relay closed outside the on state");

    // once decided, the state never returns to undecided
    a_no_return_undecided: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != trc_pkg::ST_UNDECIDED) |=> (state_reg != trc_pkg::ST_UNDECIDED))
        else $error("decided state returned to undecided");

    // state changes only with an accepted tick
    a_state_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(state_reg) && $stable(relay_reg))
        else $error("state changed without a transaction");

endmodule
